// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the message deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside of reset
`define MDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a consequent on the same edge
`define MDF_ASSERT_IMPL(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/mdf_pkg.sv =====
// ----------------------------------------------------------------------------
// mdf_pkg
// Types and constants shared by the message deframer modules.
// ----------------------------------------------------------------------------
package mdf_pkg;

	// frame layout
	localparam int MIN_FRAME_BYTES = 6;
	localparam int MAX_COUNT       = 1023;
	localparam int POS_W           = $clog2(MAX_COUNT + 1);
	localparam int HDR_BYTES       = 2;
	localparam int POS_ID          = 2;
	localparam int POS_LEN         = 3;
	localparam int PAYLOAD_START   = 4;
	localparam int LEN_OVERHEAD    = 4;
	localparam int LEN_BIAS        = 2;

	// configuration register indexes
	localparam logic CFG_HEADER = 1'b0;
	localparam logic CFG_TAIL   = 1'b1;

	// result item kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// frame status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_SHORT      = 2'd1;
	localparam logic [1:0] ST_BAD_HEADER = 2'd2;
	localparam logic [1:0] ST_BAD_TAIL   = 2'd3;

	// queue between front and back
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// output bus widths
	localparam int TDATA_W = 32;

	// one queue entry: the results caused by one input byte
	typedef struct packed {
		logic       has_pay;
		logic       has_stat;
		logic [7:0] pay_byte;
		logic [7:0] msg_id;
		logic [7:0] pay_count;
		logic [1:0] status;
		logic       mismatch;
	} mdf_entry_t;

endpackage

// ===== design/message_deframer.sv =====
// ----------------------------------------------------------------------------
// message_deframer
// Header/length/tail frame deframer with payload and status item output.
// ----------------------------------------------------------------------------
// Frame bytes enter on the s_ channel, one item per byte, s_tlast on the
// final byte. Results leave on the m_ channel: payload items (m_tuser 0) for
// frame positions 4 on, up to length-2 of them, then one status item
// (m_tuser 1, m_tlast 1) after the final byte. cfg_we writes the header
// (index 0) or tail (index 1) pattern; the user must do so only while the
// block is idle; the block does not enforce it. Each result passes the
// queue, then the output register. One byte is taken per cycle while the
// queue is not full; a final byte that also carries payload gives two
// items, sent one after the other, and the four-entry queue absorbs the
// extra item. Reset clears the patterns, the frame state and the queue;
// s_tready goes high right after reset. When the receiver holds m_tready
// low the output register and queue fill, and s_tready drops once full.
// ----------------------------------------------------------------------------
module message_deframer import mdf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] in_byte
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] payload_byte, [15:8] message_id, [23:16] payload_count,
	// [25:24] frame_status, [26] length_mismatch, [31:27] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tuser,   // [0] item_kind
	output logic               m_tlast
);

	mdf_entry_t push_entry;
	mdf_entry_t head;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;

	// byte intake and classification
	mdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// entry queue
	mdf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	// item output
	mdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ===== design/mdf_front.sv =====
// ----------------------------------------------------------------------------
// mdf_front
// Accepts frame bytes, tracks the frame position and classifies each byte.
// ----------------------------------------------------------------------------
module mdf_front import mdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             full,
	output logic             push,
	output mdf_entry_t       push_entry
);

	logic [15:0]      hdr_pat_q;
	logic [15:0]      tail_pat_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      hdr_shift_q;
	logic [15:0]      recent_q;
	logic [7:0]       id_q;
	logic [7:0]       len_q;
	logic             good_q;

	logic             accept;
	logic [POS_W-1:0] count_c;
	logic [15:0]      hdr_shift_n;
	logic [15:0]      recent_n;
	logic [7:0]       id_n;
	logic [7:0]       len_n;
	logic             good_n;
	logic [7:0]       pcount_c;
	logic             pay_c;
	logic [1:0]       status_c;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// next frame state for the byte on the input
	always_comb begin
		count_c     = (pos_q < POS_W'(MAX_COUNT)) ? pos_q + POS_W'(1) : POS_W'(MAX_COUNT);
		hdr_shift_n = (pos_q < POS_W'(HDR_BYTES)) ? {hdr_shift_q[7:0], in_byte} : hdr_shift_q;
		good_n      = (pos_q == POS_W'(HDR_BYTES - 1)) ? (hdr_shift_n == hdr_pat_q) : good_q;
		id_n        = (pos_q == POS_W'(POS_ID)) ? in_byte : id_q;
		len_n       = (pos_q == POS_W'(POS_LEN)) ? in_byte : len_q;
		recent_n    = {recent_q[7:0], in_byte};
		pcount_c    = (len_n >= 8'(LEN_BIAS)) ? len_n - 8'(LEN_BIAS) : 8'd0;
		pay_c       = (pos_q >= POS_W'(PAYLOAD_START)) &&
		              (pos_q < POS_W'(pcount_c) + POS_W'(PAYLOAD_START));
		if (count_c < POS_W'(MIN_FRAME_BYTES)) begin
			status_c = ST_SHORT;
		end else if (!good_n) begin
			status_c = ST_BAD_HEADER;
		end else if (recent_n != tail_pat_q) begin
			status_c = ST_BAD_TAIL;
		end else begin
			status_c = ST_OK;
		end
	end

	// queue entry for this byte
	always_comb begin
		push_entry.has_pay   = pay_c;
		push_entry.has_stat  = in_last;
		push_entry.pay_byte  = in_byte;
		push_entry.msg_id    = id_n;
		push_entry.pay_count = pcount_c;
		push_entry.status    = status_c;
		push_entry.mismatch  = (count_c != POS_W'(len_n) + POS_W'(LEN_OVERHEAD));
	end

	assign push = accept && (pay_c || in_last);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pat_q  <= '0;
			tail_pat_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_HEADER) begin
				hdr_pat_q <= cfg_wdata;
			end else begin
				tail_pat_q <= cfg_wdata;
			end
		end
	end

	// frame state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_shift_q <= '0;
			recent_q    <= '0;
			id_q        <= '0;
			len_q       <= '0;
			good_q      <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				pos_q       <= '0;
				hdr_shift_q <= '0;
				recent_q    <= '0;
				id_q        <= '0;
				len_q       <= '0;
				good_q      <= 1'b0;
			end else begin
				pos_q       <= count_c;
				hdr_shift_q <= hdr_shift_n;
				recent_q    <= recent_n;
				id_q        <= id_n;
				len_q       <= len_n;
				good_q      <= good_n;
			end
		end
	end

endmodule

// ===== design/mdf_fifo.sv =====
// ----------------------------------------------------------------------------
// mdf_fifo
// Short queue of classified entries between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdf_fifo import mdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mdf_entry_t push_entry,
	input  logic       pop,
	output mdf_entry_t head,
	output logic       empty,
	output logic       full
);

	mdf_entry_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (FIFO_AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (FIFO_AW + 1)'(1);
			end
		end
	end

	`MDF_ASSERT(a_no_overflow, !(push && full), "push into a full queue")
	`MDF_ASSERT(a_no_underflow, !(pop && empty), "pop from an empty queue")
	`MDF_ASSERT(a_count_bound, cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH), "queue count out of range")

endmodule

// ===== design/mdf_back.sv =====
// ----------------------------------------------------------------------------
// mdf_back
// Turns queue entries into payload and status items on the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdf_back import mdf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mdf_entry_t         head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TDATA_W-1:0] out_data,
	output logic               out_kind,
	output logic               out_last
);

	logic               valid_q;
	logic               phase_q;
	logic [TDATA_W-1:0] data_q;
	logic               kind_q;
	logic               last_q;

	logic               load;
	logic               emit_pay;

	assign load     = (!valid_q || out_ready) && !empty;
	assign emit_pay = head.has_pay && !phase_q;
	// an entry with both results stays until its status item goes out
	assign pop      = load && !(emit_pay && head.has_stat);

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= emit_pay && head.has_stat;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_pay) begin
				data_q <= TDATA_W'(head.pay_byte);
				kind_q <= KIND_PAYLOAD;
				last_q <= 1'b0;
			end else begin
				data_q <= TDATA_W'({head.mismatch, head.status, head.pay_count,
				                    head.msg_id, 8'd0});
				kind_q <= KIND_STATUS;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

	`MDF_ASSERT_IMPL(a_phase_head, phase_q, !empty && head.has_pay && head.has_stat,
		"split entry lost from queue head")

endmodule
